// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed: always");

// Hold cons whenever ante is true.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

// File: hw/rtl/tccs_pkg.sv
// Package for the text console: item kinds, controller states, command and status structs, constants.
// Shared by tccs_ctrl, tccs_dp and text_console_cursor_scroll; no dependencies.
package tccs_pkg;

  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ROW_FW     = 5;
  localparam int unsigned COL_FW     = 7;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;
  localparam logic [CODE_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HI   = 8'd126;
  localparam logic [CODE_W-1:0] BS_CODE    = 8'd8;
  localparam logic [CODE_W-1:0] LF_CODE    = 8'd10;
  localparam logic [CODE_W-1:0] DEL_CODE   = 8'd127;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_READ,
    KIND_PRINT,
    KIND_ERASE,
    KIND_LF
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_ADV,
    ST_SBLANK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic wr_en;
    logic wr_space;
    logic wr_bottom;
    logic walk_inc;
    logic cur_inc;
    logic cur_dec;
    logic newline;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_e kind;
    logic  col_zero;
    logic  col_last;
    logic  walk_last;
    logic  row_last;
    logic  out_busy;
  } status_t;

endpackage

// File: hw/rtl/tccs_ctrl.sv
// Controller of the text console: sequences clear, read, put, blank and scroll.
// Depends on tccs_pkg; drives tccs_dp through cmd_t and watches status_t.
module tccs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tccs_pkg::status_t status_i,
  output tccs_pkg::cmd_t    cmd_o
);

  tccs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccs_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tccs_pkg::ST_EXEC;
      end
      tccs_pkg::ST_EXEC: begin
        unique case (status_i.kind)
          tccs_pkg::KIND_PRINT: state_d = tccs_pkg::ST_ADV;
          tccs_pkg::KIND_LF:    state_d = tccs_pkg::ST_BLANK;
          default:              state_d = tccs_pkg::ST_DONE;
        endcase
      end
      tccs_pkg::ST_BLANK: begin
        if (status_i.walk_last) state_d = tccs_pkg::ST_ADV;
      end
      tccs_pkg::ST_ADV: begin
        if ((status_i.kind == tccs_pkg::KIND_LF || status_i.col_last) && status_i.row_last) begin
          state_d = tccs_pkg::ST_SBLANK;
        end else begin
          state_d = tccs_pkg::ST_DONE;
        end
      end
      tccs_pkg::ST_SBLANK: begin
        if (status_i.walk_last) state_d = tccs_pkg::ST_DONE;
      end
      tccs_pkg::ST_DONE: begin
        if (!status_i.out_busy) state_d = tccs_pkg::ST_IDLE;
      end
      default: state_d = tccs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tccs_pkg::ST_CLEAR: cmd_o.clr_we = 1'b1;
      tccs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      tccs_pkg::ST_EXEC: begin
        unique case (status_i.kind)
          tccs_pkg::KIND_READ:  cmd_o.rd_en = 1'b1;
          tccs_pkg::KIND_PRINT: cmd_o.wr_en = 1'b1;
          tccs_pkg::KIND_ERASE: begin
            cmd_o.wr_en    = !status_i.col_zero;
            cmd_o.wr_space = 1'b1;
            cmd_o.cur_dec  = !status_i.col_zero;
          end
          default: ;
        endcase
      end
      tccs_pkg::ST_BLANK: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_space = 1'b1;
        cmd_o.walk_inc = !status_i.walk_last;
      end
      tccs_pkg::ST_ADV: begin
        if (status_i.kind == tccs_pkg::KIND_LF || status_i.col_last) begin
          cmd_o.newline = 1'b1;
        end else begin
          cmd_o.cur_inc = 1'b1;
        end
      end
      tccs_pkg::ST_SBLANK: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_space  = 1'b1;
        cmd_o.wr_bottom = 1'b1;
        cmd_o.walk_inc  = !status_i.walk_last;
      end
      tccs_pkg::ST_DONE: cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/tccs_dp.sv
// Datapath of the text console: grid memory with rotating row base, cursor,
// walk column, clear counter and output register. Depends on tccs_pkg.
module tccs_dp #(
  parameter int unsigned ROWS = 30,
  parameter int unsigned COLS = 80
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tccs_pkg::cmd_t                    cmd_i,
  output tccs_pkg::status_t                 status_o,
  input  logic                              in_op_i,
  input  logic [tccs_pkg::CODE_W-1:0]       in_code_i,
  input  logic [tccs_pkg::ROW_FW-1:0]       in_row_i,
  input  logic [tccs_pkg::COL_FW-1:0]       in_col_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tccs_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned AW    = $clog2(CELLS);

  logic [tccs_pkg::CHAR_W-1:0] mem [CELLS];
  logic [tccs_pkg::CHAR_W-1:0] rdata_q;

  logic [RW-1:0] cur_row_q, base_q;
  logic [CW-1:0] cur_col_q, walk_q;
  logic [AW-1:0] clr_q;
  logic          scrolled_q;
  logic          out_valid_q;
  logic [tccs_pkg::OUT_DATA_W-1:0] out_data_q;

  tccs_pkg::kind_e             kind_q, kind_d;
  logic [tccs_pkg::CHAR_W-1:0] code_q;
  logic [tccs_pkg::ROW_FW-1:0] item_row_q;
  logic [tccs_pkg::COL_FW-1:0] item_col_q;

  logic          row_last, in_range, is_cur;
  logic [RW-1:0] wr_lrow, wr_prow, rd_prow, base_inc;
  logic [RW:0]   wr_sum, rd_sum;
  logic [AW-1:0] waddr, raddr, mem_waddr;
  logic [tccs_pkg::CHAR_W-1:0] mem_wdata;
  logic          mem_we;

  always_comb begin
    if (in_op_i == tccs_pkg::OP_READ) begin
      kind_d = tccs_pkg::KIND_READ;
    end else if (in_code_i >= tccs_pkg::PRINT_LO && in_code_i <= tccs_pkg::PRINT_HI) begin
      kind_d = tccs_pkg::KIND_PRINT;
    end else if (in_code_i == tccs_pkg::BS_CODE || in_code_i == tccs_pkg::DEL_CODE) begin
      kind_d = tccs_pkg::KIND_ERASE;
    end else if (in_code_i == tccs_pkg::LF_CODE) begin
      kind_d = tccs_pkg::KIND_LF;
    end else begin
      kind_d = tccs_pkg::KIND_NOP;
    end
  end

  assign row_last = (cur_row_q == RW'(ROWS - 1));

  assign wr_lrow = cmd_i.wr_bottom ? RW'(ROWS - 1) : cur_row_q;
  assign wr_sum  = {1'b0, wr_lrow} + {1'b0, base_q};
  assign wr_prow = (wr_sum >= (RW + 1)'(ROWS)) ? RW'(wr_sum - (RW + 1)'(ROWS)) : RW'(wr_sum);
  assign waddr   = AW'(wr_prow * COLS) + AW'(walk_q);

  assign rd_sum  = {1'b0, RW'(item_row_q)} + {1'b0, base_q};
  assign rd_prow = (rd_sum >= (RW + 1)'(ROWS)) ? RW'(rd_sum - (RW + 1)'(ROWS)) : RW'(rd_sum);
  assign raddr   = AW'(rd_prow * COLS) + AW'(CW'(item_col_q));

  assign base_inc = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);

  assign mem_we    = cmd_i.clr_we || cmd_i.wr_en;
  assign mem_waddr = cmd_i.clr_we ? clr_q : waddr;
  assign mem_wdata = cmd_i.clr_we ? '0 : (cmd_i.wr_space ? tccs_pkg::SPACE_CHAR : code_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q     <= in_code_i[tccs_pkg::CHAR_W-1:0];
      item_row_q <= in_row_i;
      item_col_q <= in_col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= tccs_pkg::KIND_NOP;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      base_q     <= '0;
      walk_q     <= '0;
      clr_q      <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        kind_q     <= kind_d;
        walk_q     <= cur_col_q;
        scrolled_q <= 1'b0;
      end
      if (cmd_i.walk_inc) begin
        walk_q <= walk_q + CW'(1);
      end
      if (cmd_i.cur_inc) begin
        cur_col_q <= cur_col_q + CW'(1);
      end
      if (cmd_i.cur_dec) begin
        cur_col_q <= cur_col_q - CW'(1);
      end
      if (cmd_i.newline) begin
        cur_col_q <= '0;
        if (row_last) begin
          base_q     <= base_inc;
          walk_q     <= '0;
          scrolled_q <= 1'b1;
        end else begin
          cur_row_q <= cur_row_q + RW'(1);
        end
      end
    end
  end

  assign in_range = (kind_q == tccs_pkg::KIND_READ)
                 && (32'(item_row_q) < ROWS) && (32'(item_col_q) < COLS);
  assign is_cur   = in_range && (32'(item_row_q) == 32'(cur_row_q))
                 && (32'(item_col_q) == 32'(cur_col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {3'b000,
                     scrolled_q,
                     tccs_pkg::COL_FW'(cur_col_q),
                     tccs_pkg::ROW_FW'(cur_row_q),
                     is_cur,
                     in_range ? rdata_q : tccs_pkg::CHAR_W'(0)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.clr_last  = (clr_q == AW'(CELLS - 1));
  assign status_o.kind      = kind_q;
  assign status_o.col_zero  = (cur_col_q == '0);
  assign status_o.col_last  = (cur_col_q == CW'(COLS - 1));
  assign status_o.walk_last = (walk_q == CW'(COLS - 1));
  assign status_o.row_last  = row_last;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// File: hw/rtl/text_console_cursor_scroll.sv
// Text console top level: a read, an erase or an ignored code passes EXEC and DONE after
// accept, a printable put EXEC, ADV and DONE, a line feed also blanks the rest of the row in
// BLANK, and a scroll blanks the new bottom row in SBLANK; the grid memory writes one cell per cycle.
// One item at a time; the next is taken once the result sits in the output register.
// After reset the grid clears every cell before the first item is taken.
// Depends on tccs_pkg, tccs_ctrl, tccs_dp and assert_macros.svh.
`include "assert_macros.svh"
module text_console_cursor_scroll #(
  parameter int unsigned ROWS = 30,
  parameter int unsigned COLS = 80
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero[23:20]
  input  logic [tccs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // operation[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cell_char[6:0], cell_is_cursor[7], cursor_row_out[12:8],
  // cursor_col_out[19:13], did_scroll[20], zero[23:21]
  output logic [tccs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  tccs_pkg::cmd_t    cmd;
  tccs_pkg::status_t status;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tccs_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_op_i     (s_axis_tuser),
    .in_code_i   (s_axis_tdata[7:0]),
    .in_row_i    (s_axis_tdata[12:8]),
    .in_col_i    (s_axis_tdata[19:13]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  `ASSERT_IMPLIES(a_no_accept_while_clearing, cmd.clr_we, !s_axis_tready)
  `ASSERT_IMPLIES(a_no_write_during_clear, cmd.wr_en, !cmd.clr_we)
  `ASSERT_IMPLIES(a_no_result_overwrite, cmd.out_load, !(m_axis_tvalid && !m_axis_tready))
  `ASSERT_IMPLIES(a_cursor_row_in_grid, m_axis_tvalid, 32'(m_axis_tdata[12:8]) < ROWS)

endmodule
